[rtl/core/lkarc_pkg.sv]
// Shared types and constants for the Lehmer keyed ASCII rotation cipher.
package lkarc_pkg;

  localparam int SEED_W = 17;
  localparam int DATA_W = 8;
  localparam int MULT_W = 7;
  localparam int PROD_W = SEED_W + MULT_W;
  localparam int HALF_W = 16;
  localparam int POS_W  = 7;

  typedef logic [SEED_W-1:0] seed_t;
  typedef logic [DATA_W-1:0] data_t;
  typedef logic [POS_W-1:0]  pos_t;

  localparam logic [MULT_W-1:0] LEHMER_MULT = 7'd75;
  localparam seed_t             FOLD_MOD    = 17'd65537;
  localparam seed_t             SEED_RESET  = 17'd1;
  localparam data_t             CHAR_LOW    = 8'd32;
  localparam data_t             CHAR_SPAN   = 8'd96;
  // ceil(2^16 / 3): exact quotient by 3 for 12-bit operands
  localparam logic [14:0]       RECIP3      = 15'd21846;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_INITIAL_SEED = 1'b0,
    REG_DECRYPT_MODE = 1'b1
  } cfg_reg_t;

  // generator stage output toward the rotate stage
  typedef struct packed {
    logic  valid;
    data_t data;
    seed_t rnd;
  } lkarc_s1_t;

endpackage

[rtl/core/lkarc_if.sv]
// Channel interfaces: input items, result items and configuration writes.
interface lkarc_in_if;
  logic              valid;
  logic              ready;
  lkarc_pkg::data_t  in_byte;
  logic              restart;
  modport source (output valid, output in_byte, output restart, input ready);
  modport sink   (input valid, input in_byte, input restart, output ready);
endinterface

interface lkarc_out_if;
  logic              valid;
  logic              ready;
  lkarc_pkg::data_t  out_byte;
  modport source (output valid, output out_byte, input ready);
  modport sink   (input valid, input out_byte, output ready);
endinterface

interface lkarc_cfg_if;
  logic                  valid;
  logic                  ready;
  lkarc_pkg::cfg_reg_t   index;
  lkarc_pkg::seed_t      data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/lkarc_prng.sv]
// Input stage: Lehmer generator step (x75 mod 65537) and item register.
module lkarc_prng (
  input  logic                 clk,
  input  logic                 rst_n,
  lkarc_in_if.sink             in_ch,
  input  lkarc_pkg::seed_t     initial_seed,
  input  logic                 s1_ready,
  output lkarc_pkg::lkarc_s1_t s1
);

  lkarc_pkg::seed_t                   state_r;
  lkarc_pkg::seed_t                   state_nxt;
  lkarc_pkg::seed_t                   base;
  logic [lkarc_pkg::PROD_W-1:0]       prod;
  logic [lkarc_pkg::HALF_W-1:0]       lo;
  logic [lkarc_pkg::PROD_W-lkarc_pkg::HALF_W-1:0] hi;
  lkarc_pkg::seed_t                   diff;
  logic                               accept;
  logic                               valid_r;
  lkarc_pkg::data_t                   data_r;
  lkarc_pkg::seed_t                   rnd_r;

  assign in_ch.ready = !valid_r || s1_ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // fold: low half minus high part, add modulus back when it went negative
  always_comb begin
    base = in_ch.restart ? initial_seed : state_r;
    prod = lkarc_pkg::PROD_W'(base) * lkarc_pkg::PROD_W'(lkarc_pkg::LEHMER_MULT);
    lo   = prod[lkarc_pkg::HALF_W-1:0];
    hi   = prod[lkarc_pkg::PROD_W-1:lkarc_pkg::HALF_W];
    diff = lkarc_pkg::SEED_W'(lo) - lkarc_pkg::SEED_W'(hi);
    if (lo >= lkarc_pkg::HALF_W'(hi)) begin
      state_nxt = diff;
    end else begin
      state_nxt = diff + lkarc_pkg::FOLD_MOD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lkarc_pkg::SEED_RESET;
      valid_r <= 1'b0;
    end else begin
      if (accept) begin
        state_r <= state_nxt;
      end
      if (in_ch.ready) begin
        valid_r <= in_ch.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_r <= in_ch.in_byte;
      rnd_r  <= state_nxt;
    end
  end

  assign s1.valid = valid_r;
  assign s1.data  = data_r;
  assign s1.rnd   = rnd_r;

endmodule

[rtl/core/lkarc_rotate.sv]
// Result stage: key mod 96, rotate printable bytes, output register.
module lkarc_rotate (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lkarc_pkg::lkarc_s1_t s1,
  output logic                 s1_ready,
  input  logic                 decrypt_mode,
  lkarc_out_if.source          out_ch
);

  logic [11:0]       hi12;
  logic [26:0]       qprod;
  logic [10:0]       q3;
  logic [11:0]       rem3;
  lkarc_pkg::pos_t   key;
  lkarc_pkg::data_t  pos;
  lkarc_pkg::data_t  sum;
  lkarc_pkg::data_t  res;
  logic              printable;
  logic              out_valid_r;
  lkarc_pkg::data_t  out_byte_r;

  assign s1_ready = !out_valid_r || out_ch.ready;

  // r mod 96 = ((r >> 5) mod 3) * 32 + r[4:0]
  always_comb begin
    hi12  = s1.rnd[16:5];
    qprod = 27'(hi12) * 27'(lkarc_pkg::RECIP3);
    q3    = qprod[26:16];
    rem3  = hi12 - 12'(q3) * 12'd3;
    key   = {rem3[1:0], s1.rnd[4:0]};
  end

  always_comb begin
    printable = (s1.data >= lkarc_pkg::CHAR_LOW) && !s1.data[7];
    pos       = s1.data - lkarc_pkg::CHAR_LOW;
    if (decrypt_mode) begin
      sum = pos - lkarc_pkg::DATA_W'(key);
      if (pos < lkarc_pkg::DATA_W'(key)) begin
        sum = sum + lkarc_pkg::CHAR_SPAN;
      end
    end else begin
      sum = pos + lkarc_pkg::DATA_W'(key);
      if (sum >= lkarc_pkg::CHAR_SPAN) begin
        sum = sum - lkarc_pkg::CHAR_SPAN;
      end
    end
    res = printable ? (sum + lkarc_pkg::CHAR_LOW) : s1.data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_ready) begin
      out_valid_r <= s1.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1.valid && s1_ready) begin
      out_byte_r <= res;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;

endmodule

[rtl/core/lehmer_keyed_ascii_rotation_cipher.sv]
// Path from input accept to result accept: generator register, then rotate stage output register.
// Throughput: 1 item per cycle absent output stall; the generator's x75 fold is combinational.
// Under output stall one more item can enter behind the waiting result, then input stalls.
// Reset (rst_n low, synchronous): generator = 1, initial_seed = 1, decrypt_mode = 0,
// pipeline emptied. Configuration writes are always ready.
module lehmer_keyed_ascii_rotation_cipher (
  input  logic         clk,
  input  logic         rst_n,
  lkarc_in_if.sink     in_ch,
  lkarc_out_if.source  out_ch,
  lkarc_cfg_if.sink    cfg_ch
);

  lkarc_pkg::seed_t     initial_seed_r;
  logic                 decrypt_mode_r;
  lkarc_pkg::lkarc_s1_t s1;
  logic                 s1_ready;

  // config registers; the user must write only while idle, the block does not enforce it
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      initial_seed_r <= lkarc_pkg::SEED_RESET;
      decrypt_mode_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        lkarc_pkg::REG_INITIAL_SEED: initial_seed_r <= cfg_ch.data;
        lkarc_pkg::REG_DECRYPT_MODE: decrypt_mode_r <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // stage 1: restart mux + generator advance, one step per accepted item
  lkarc_prng u_prng (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .initial_seed (initial_seed_r),
    .s1_ready     (s1_ready),
    .s1           (s1)
  );

  // stage 2: rotate 32..127 by r mod 96, others pass through
  lkarc_rotate u_rotate (
    .clk          (clk),
    .rst_n        (rst_n),
    .s1           (s1),
    .s1_ready     (s1_ready),
    .decrypt_mode (decrypt_mode_r),
    .out_ch       (out_ch)
  );

endmodule

[test/lehmer_keyed_ascii_rotation_cipher_test.sv]
// Self-checking testbench for the Lehmer keyed ASCII rotation cipher.
module lehmer_keyed_ascii_rotation_cipher_test;

  // generator and rotation constants, written out as plain integers
  localparam int unsigned GEN_MULT   = 75;
  localparam int unsigned GEN_MOD    = 65537;
  localparam int unsigned ASCII_LOW  = 32;
  localparam int unsigned ASCII_SPAN = 96;
  localparam int          RAND_PHASES = 8;
  localparam int          PHASE_ITEMS = 115;
  // block latency is two stages; leave some margin before touching config
  localparam int          SETTLE_CYCLES = 6;
  localparam int          TIMEOUT_TU    = 2000000;

  typedef struct {
    lkarc_pkg::data_t value;
    logic             restart;
  } stream_item_t;

  logic clk = 1'b0;
  logic rst_n;

  lkarc_in_if  in_ch ();
  lkarc_out_if out_ch ();
  lkarc_cfg_if cfg_ch ();

  lehmer_keyed_ascii_rotation_cipher i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // bytes waiting to be sent, and cipher bytes waiting to come back
  stream_item_t     pending_items[$];
  lkarc_pkg::data_t expected_bytes[$];

  // shadow copy of the generator and both registers
  lkarc_pkg::seed_t gen_state;
  lkarc_pkg::seed_t key_seed;
  logic             decrypt_on;

  int          fail_count;
  int          burst_left;
  int          gap_left;
  int unsigned stall_tick;
  stream_item_t drive_item;

  // One Lehmer step: fold the x75 product as low half minus high part,
  // adding the modulus back when that goes negative.
  function automatic lkarc_pkg::seed_t lehmer_next(lkarc_pkg::seed_t s);
    logic [23:0]      prod;
    lkarc_pkg::seed_t lo;
    lkarc_pkg::seed_t hi;
    prod = s * 24'(GEN_MULT);
    lo   = {1'b0, prod[15:0]};
    hi   = {9'b0, prod[23:16]};
    if (lo >= hi) return lo - hi;
    return lo + lkarc_pkg::seed_t'(GEN_MOD) - hi;
  endfunction

  // Rotate a printable byte by r mod 96; anything else goes through as is.
  function automatic lkarc_pkg::data_t rotate_byte(lkarc_pkg::data_t b, lkarc_pkg::seed_t r,
                                                   logic back);
    int unsigned k;
    int unsigned pos;
    if (b < ASCII_LOW || b >= ASCII_LOW + ASCII_SPAN) return b;
    k   = r % ASCII_SPAN;
    pos = b - ASCII_LOW;
    if (back) pos = (pos + ASCII_SPAN - k) % ASCII_SPAN;
    else      pos = (pos + k) % ASCII_SPAN;
    return lkarc_pkg::data_t'(pos + ASCII_LOW);
  endfunction

  // Sender: bursts of random length separated by random gaps. Each
  // accepted item advances the shadow generator and queues its cipher byte.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.restart) gen_state = key_seed;
        gen_state = lehmer_next(gen_state);
        expected_bytes.push_back(rotate_byte(in_ch.in_byte, gen_state, decrypt_on));
      end
      // an item offered but not taken stays on the bus untouched
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          drive_item = pending_items.pop_front();
          in_ch.valid   <= 1'b1;
          in_ch.in_byte <= drive_item.value;
          in_ch.restart <= drive_item.restart;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            // a third of the bursts run straight into the next one
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 20);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each accepted byte against the oldest expectation.
  // Ready follows a pattern that cycles through free flow, coin flips,
  // a fixed duty cycle and heavy back-pressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_tick = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_bytes.size() == 0) begin
          $error("out_byte: expected nothing, actual %0d", out_ch.out_byte);
          fail_count++;
        end else if (out_ch.out_byte !== expected_bytes[0]) begin
          $error("out_byte: expected %0d, actual %0d", expected_bytes[0], out_ch.out_byte);
          fail_count++;
          void'(expected_bytes.pop_front());
        end else begin
          void'(expected_bytes.pop_front());
        end
      end
      stall_tick++;
      case ((stall_tick / 128) % 4)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= 1'($urandom_range(0, 1));
        2:       out_ch.ready <= (stall_tick % 8) >= 3;
        default: out_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Register write; the shadow copy changes only while nothing is in flight.
  task automatic write_reg(lkarc_pkg::cfg_reg_t idx, lkarc_pkg::seed_t val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == lkarc_pkg::REG_INITIAL_SEED) key_seed = val;
    else                                    decrypt_on = val[0];
  endtask

  // Waits until every queued item is taken and every cipher
  // byte is back, then lets the pipeline settle.
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_items.size() != 0 || in_ch.valid || expected_bytes.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_byte(int unsigned value, logic restart);
    stream_item_t it;
    it.value   = lkarc_pkg::data_t'(value);
    it.restart = restart;
    pending_items.push_back(it);
  endtask

  // Random traffic, mostly messages that start with a restart and carry
  // printable text, plus stray bytes over the full 0..255 range.
  task automatic queue_messages(int count);
    int msg_left;
    msg_left = 0;
    repeat (count) begin
      if (msg_left == 0) begin
        msg_left = $urandom_range(1, 40);
        queue_byte(($urandom_range(0, 4) != 0) ? $urandom_range(32, 127)
                                               : $urandom_range(0, 255),
                   ($urandom_range(0, 6) != 0));
      end else begin
        queue_byte(($urandom_range(0, 4) != 0) ? $urandom_range(32, 127)
                                               : $urandom_range(0, 255),
                   ($urandom_range(0, 30) == 0));
      end
      msg_left--;
    end
  endtask

  initial begin
    lkarc_pkg::seed_t phase_seed;
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.in_byte  = '0;
    in_ch.restart  = 1'b0;
    out_ch.ready   = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = lkarc_pkg::REG_INITIAL_SEED;
    cfg_ch.data    = '0;
    gen_state      = lkarc_pkg::SEED_RESET;
    key_seed       = lkarc_pkg::SEED_RESET;
    decrypt_on     = 1'b0;
    fail_count     = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, on reset values: range edges, bytes just outside the
    // printable window, high bytes, alternating bit patterns, restarts.
    @(negedge clk);
    queue_byte(32, 1'b0);
    queue_byte(127, 1'b0);
    queue_byte(31, 1'b0);
    queue_byte(0, 1'b0);
    queue_byte(128, 1'b0);
    queue_byte(255, 1'b0);
    queue_byte(33, 1'b1);
    queue_byte(126, 1'b0);
    queue_byte(85, 1'b0);
    queue_byte(170, 1'b1);
    queue_byte(64, 1'b0);
    queue_byte(96, 1'b1);
    queue_byte(1, 1'b0);
    queue_byte(200, 1'b0);
    wait_drained();

    // Decrypt with the top in-range seed.
    write_reg(lkarc_pkg::REG_INITIAL_SEED, 17'd65536);
    write_reg(lkarc_pkg::REG_DECRYPT_MODE, 17'd1);
    @(negedge clk);
    queue_byte(32, 1'b1);
    queue_byte(127, 1'b0);
    queue_byte(80, 1'b0);
    wait_drained();

    // Seed zero: generator stuck at zero, printable bytes unrotated.
    write_reg(lkarc_pkg::REG_INITIAL_SEED, 17'd0);
    write_reg(lkarc_pkg::REG_DECRYPT_MODE, 17'd0);
    @(negedge clk);
    queue_byte(32, 1'b1);
    queue_byte(127, 1'b0);
    queue_byte(77, 1'b0);
    wait_drained();

    // Seed above the modulus: first fold must bring it back into range.
    write_reg(lkarc_pkg::REG_INITIAL_SEED, 17'h1FFFF);
    write_reg(lkarc_pkg::REG_DECRYPT_MODE, 17'd1);
    @(negedge clk);
    queue_byte(127, 1'b1);
    queue_byte(32, 1'b0);
    queue_byte(90, 1'b1);
    wait_drained();

    // Random phases, each under its own key and direction; the list
    // revisits the extremes before moving to random keys.
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0:       phase_seed = 17'd1;
        1:       phase_seed = 17'd65536;
        2:       phase_seed = 17'd0;
        3:       phase_seed = 17'd65537;
        4:       phase_seed = 17'h1FFFF;
        default: phase_seed = lkarc_pkg::seed_t'($urandom_range(0, 131071));
      endcase
      write_reg(lkarc_pkg::REG_INITIAL_SEED, phase_seed);
      write_reg(lkarc_pkg::REG_DECRYPT_MODE,
                lkarc_pkg::seed_t'(p % 2 == 1 || p >= 5 && $urandom_range(0, 1)));
      @(negedge clk);
      queue_messages(PHASE_ITEMS);
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #TIMEOUT_TU;
    $display("tb: failure");
    $finish;
  end

endmodule

[files.f]
rtl/core/lkarc_pkg.sv
rtl/core/lkarc_if.sv
rtl/core/lkarc_prng.sv
rtl/core/lkarc_rotate.sv
rtl/core/lehmer_keyed_ascii_rotation_cipher.sv
test/lehmer_keyed_ascii_rotation_cipher_test.sv
